// ===== design/etr_pkg.sv =====
// Package for the email token recognizer: constants, class and phase codes,
// the queue beat type and the code unit classifier shared by the front and back.
// No dependencies.
package etr_pkg;

  // Most dots allowed after the '@' sign.
  localparam int unsigned MAX_DOMAIN_DOTS = 3;
  localparam int unsigned DOT_W = $clog2(MAX_DOMAIN_DOTS + 1);

  // Depth of the queue between the classifier and the matcher.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [15:0] CH_UPPER_A = 16'h0041;
  localparam logic [15:0] CH_UPPER_Z = 16'h005A;
  localparam logic [15:0] CH_LOWER_A = 16'h0061;
  localparam logic [15:0] CH_LOWER_Z = 16'h007A;
  localparam logic [15:0] CH_CYR_FIRST = 16'h0410;
  localparam logic [15:0] CH_CYR_LAST = 16'h044F;
  localparam logic [15:0] CH_DIGIT_0 = 16'h0030;
  localparam logic [15:0] CH_DIGIT_9 = 16'h0039;
  localparam logic [15:0] CH_DASH = 16'h002D;
  localparam logic [15:0] CH_UNDERSCORE = 16'h005F;
  localparam logic [15:0] CH_DOT = 16'h002E;
  localparam logic [15:0] CH_AT = 16'h0040;

  typedef enum logic [2:0] {
    CL_LABEL,
    CL_UNDERSCORE,
    CL_DOT,
    CL_AT,
    CL_OTHER
  } unit_class_e;

  typedef enum logic [2:0] {
    PH_START,
    PH_LOGIN,
    PH_AT_SEEN,
    PH_FIRST_LABEL,
    PH_AFTER_DOT,
    PH_LATER_LABEL,
    PH_DEAD
  } match_phase_e;

  typedef struct packed {
    unit_class_e cls;
    logic        last;
  } unit_beat_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // Both letter cases fold to the same class, so the ranges are tested directly.
  // The Cyrillic range covers upper and lower case without the two Yo letters.
  function automatic unit_class_e classify_unit(logic [15:0] u);
    unit_class_e cls;
    if ((u >= CH_UPPER_A && u <= CH_UPPER_Z) || (u >= CH_LOWER_A && u <= CH_LOWER_Z) ||
        (u >= CH_CYR_FIRST && u <= CH_CYR_LAST) ||
        (u >= CH_DIGIT_0 && u <= CH_DIGIT_9) || u == CH_DASH) begin
      cls = CL_LABEL;
    end else if (u == CH_UNDERSCORE) begin
      cls = CL_UNDERSCORE;
    end else if (u == CH_DOT) begin
      cls = CL_DOT;
    end else if (u == CH_AT) begin
      cls = CL_AT;
    end else begin
      cls = CL_OTHER;
    end
    return cls;
  endfunction

endpackage

// ===== design/etr_classify.sv =====
// Front end of the email token recognizer: turns a code unit into a class beat.
// Depends on etr_pkg.
module etr_classify (
  input  logic [15:0]        code_unit_i,
  input  logic               last_unit_i,
  output etr_pkg::unit_beat_t beat_o
);
  import etr_pkg::*;

  always_comb begin
    beat_o.cls  = classify_unit(code_unit_i);
    beat_o.last = last_unit_i;
  end

endmodule

// ===== design/etr_queue.sv =====
// Short queue of class beats between the classifier and the matcher.
// Depends on etr_pkg.
module etr_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  etr_pkg::unit_beat_t    push_beat_i,
  input  logic                   pop_i,
  output etr_pkg::unit_beat_t    head_beat_o,
  output etr_pkg::queue_status_t status_o
);
  import etr_pkg::*;

  unit_beat_t          mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]   count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_beat_i;
    end
  end

  assign head_beat_o     = mem_q[rd_ptr_q];
  assign status_o.full   = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign status_o.empty  = (count_q == '0);

endmodule

// ===== design/etr_match.sv =====
// Back end of the email token recognizer: the pattern state machine and the
// result register. Depends on etr_pkg.
module etr_match (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                head_valid_i,
  input  etr_pkg::unit_beat_t head_beat_i,
  output logic                pop_o,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output logic                is_email_o
);
  import etr_pkg::*;

  match_phase_e       phase_q, phase_d, phase_nx;
  logic [DOT_W-1:0]   dot_q, dot_d, dot_nx;
  logic               out_valid_q, out_valid_d;
  logic               is_email_q;
  logic               out_free;
  logic               match_now;
  logic               finish;

  // Transition of the pattern automaton for the beat at the queue head.
  always_comb begin
    phase_nx = PH_DEAD;
    dot_nx   = dot_q;
    case (phase_q)
      PH_START, PH_LOGIN: begin
        if (head_beat_i.cls == CL_LABEL || head_beat_i.cls == CL_UNDERSCORE ||
            head_beat_i.cls == CL_DOT) begin
          phase_nx = PH_LOGIN;
        end else if (head_beat_i.cls == CL_AT && phase_q == PH_LOGIN) begin
          phase_nx = PH_AT_SEEN;
        end
      end
      PH_AT_SEEN: begin
        if (head_beat_i.cls == CL_LABEL) begin
          phase_nx = PH_FIRST_LABEL;
        end
      end
      PH_FIRST_LABEL, PH_LATER_LABEL: begin
        if (head_beat_i.cls == CL_LABEL) begin
          phase_nx = phase_q;
        end else if (head_beat_i.cls == CL_DOT && dot_q < DOT_W'(MAX_DOMAIN_DOTS)) begin
          phase_nx = PH_AFTER_DOT;
          dot_nx   = dot_q + DOT_W'(1);
        end
      end
      PH_AFTER_DOT: begin
        if (head_beat_i.cls == CL_LABEL) begin
          phase_nx = PH_LATER_LABEL;
        end
      end
      default: begin
        phase_nx = PH_DEAD;
      end
    endcase
  end

  // Next state: a token's last beat puts the automaton back at the start.
  always_comb begin
    phase_d     = phase_q;
    dot_d       = dot_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (pop_o) begin
      if (head_beat_i.last) begin
        phase_d     = PH_START;
        dot_d       = '0;
        out_valid_d = 1'b1;
      end else begin
        phase_d = phase_nx;
        dot_d   = dot_nx;
      end
    end
  end

  // Outputs: a beat that ends a token waits until the result register is free.
  always_comb begin
    out_free  = !out_valid_q || !out_stall_i;
    pop_o     = head_valid_i && (!head_beat_i.last || out_free);
    finish    = pop_o && head_beat_i.last;
    match_now = (phase_nx == PH_LATER_LABEL) && (dot_nx >= DOT_W'(1)) &&
                (dot_nx <= DOT_W'(MAX_DOMAIN_DOTS));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_START;
      dot_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      dot_q       <= dot_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      is_email_q <= match_now;
    end
  end

  assign out_valid_o = out_valid_q;
  assign is_email_o  = is_email_q;

endmodule

// ===== design/email_token_recognizer.sv =====
// Top level of the email token recognizer: classifier, beat queue and matcher.
// Depends on etr_pkg, etr_classify, etr_queue and etr_match.
//
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid_i/in_stall_o    code_unit_i[15:0], last_unit_i
//   out      output     out_valid_o/out_stall_i  is_email_o
//
// One code unit beat is taken per cycle while the queue is not full. A beat is
// classified as it arrives and written into a two-entry queue; the matcher takes
// one queued beat per cycle, holding a last beat while the result is stalled.
// Reset is asynchronous and active low; it empties the queue, puts the matcher at
// the start of a token and drops out_valid_o.
// in_stall_o is high only while the queue is full. A stalled result holds the
// matcher at the next token's last beat; earlier beats keep flowing.
module email_token_recognizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] code_unit_i,
  input  logic        last_unit_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        is_email_o
);
  import etr_pkg::*;

  unit_beat_t    in_beat;
  unit_beat_t    head_beat;
  queue_status_t q_status;
  logic          push;
  logic          pop;

  // Front: the class of each unit is found before it enters the queue, so the
  // matcher only ever sees a small class code and the last-unit flag.
  etr_classify u_classify (
    .code_unit_i (code_unit_i),
    .last_unit_i (last_unit_i),
    .beat_o      (in_beat)
  );

  // A beat is accepted whenever the queue has room; the stall depends on the
  // registered fill level alone.
  assign in_stall_o = q_status.full;
  assign push       = in_valid_i && !q_status.full;

  etr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_beat_i (in_beat),
    .pop_i       (pop),
    .head_beat_o (head_beat),
    .status_o    (q_status)
  );

  // Back: the automaton steps on each popped beat and loads the result register
  // at the end of a token.
  etr_match u_match (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (!q_status.empty),
    .head_beat_i  (head_beat),
    .pop_o        (pop),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .is_email_o   (is_email_o)
  );

`ifndef SYNTHESIS
  // The queue fill level can never read as both full and empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_status.full && q_status.empty))
    else $error("queue reports full and empty at once");

  // Popping a token's last beat always presents a result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && head_beat.last) |=> out_valid_o)
    else $error("token end popped without a result");

  // A taken result is not repeated unless another token ended in that cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !(pop && head_beat.last)) |=> !out_valid_o)
    else $error("result delivered twice");

  // Nothing is popped from an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_status.empty |-> !pop)
    else $error("pop from empty queue");
`endif

endmodule
